// ----- hdl/bsa_pkg.sv -----
// Shared types and constants for the bucket sort block.
// Used by bsa_cell, bucket_sort_ascending and bsa_checker; depends on nothing.
package bsa_pkg;

  localparam int unsigned ValW     = 15;
  localparam int unsigned MaxItems = 64;

  typedef struct packed {
    logic [ValW-1:0] item_value;
    logic            is_last;
  } in_item_t;

  typedef struct packed {
    logic [ValW-1:0] sorted_value;
    logic            last_out;
    logic            overflowed;
  } out_item_t;

  // contents of one cell of the sorted chain
  typedef struct packed {
    logic            vld;
    logic [ValW-1:0] val;
  } cell_t;

  // broadcast control from the top level to every cell
  typedef struct packed {
    logic            ins_en;
    logic            shift_en;
    logic [ValW-1:0] value;
  } cell_ctl_t;

endpackage

// ----- hdl/bsa_cell.sv -----
// One cell of the sorted insertion chain: holds one value and a valid bit.
// Depends on bsa_pkg.
module bsa_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  bsa_pkg::cell_ctl_t ctl_i,
  input  bsa_pkg::cell_t    left_i,
  input  logic              left_open_i,
  input  bsa_pkg::cell_t    right_i,
  output bsa_pkg::cell_t    q_o,
  output logic              open_o
);
  import bsa_pkg::*;

  logic            vld_q, vld_d;
  logic [ValW-1:0] val_q, val_d;

  // open: empty, or holds a value the new one must go in front of
  assign open_o = !vld_q || (val_q > ctl_i.value);

  always_comb begin
    vld_d = vld_q;
    val_d = val_q;
    if (ctl_i.shift_en) begin
      vld_d = right_i.vld;
      val_d = right_i.val;
    end else if (ctl_i.ins_en && open_o) begin
      if (left_open_i) begin
        vld_d = left_i.vld;
        val_d = left_i.val;
      end else begin
        vld_d = 1'b1;
        val_d = ctl_i.value;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign q_o.vld = vld_q;
  assign q_o.val = val_q;

endmodule

// ----- hdl/bucket_sort_ascending.sv -----
// Bucket sort block top level: chain of insertion cells plus load/drain control.
// Depends on bsa_pkg and bsa_cell.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_data_i) takes one item per
//   cycle while loading. Each item is placed into its sorted position in a
//   row of MAX_ITEMS cells in the cycle it is accepted. Once the store is
//   full, further items are dropped and the overflow flag is set.
//   An item with is_last starts the drain: in_stall_o stays high and the
//   cells shift toward cell 0, one item per cycle while out_stall_i is low,
//   on the output channel (out_valid_o / out_stall_i / out_data_o), smallest
//   first. The largest value carries last_out; every item of the set carries
//   overflowed if an item was dropped. The first result appears in the cycle
//   after the last item is accepted. Loading and draining do not overlap: a
//   new set is taken only after the last result has left.
//   A stalled output holds cell 0 and the whole chain in place.
//   Reset clears all valid bits, the overflow flag and the drain state;
//   the block is ready for a new set right after reset.
module bucket_sort_ascending #(
  parameter int unsigned MAX_ITEMS = bsa_pkg::MaxItems
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  bsa_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output bsa_pkg::out_item_t out_data_o
);
  import bsa_pkg::*;

  cell_t     cell_q  [MAX_ITEMS];
  logic      open_w  [MAX_ITEMS];
  cell_ctl_t ctl;

  logic drain_q, drain_d;
  logic ovf_q, ovf_d;
  logic in_acc, full, drain_end;

  assign in_acc    = in_valid_i && !drain_q;
  assign full      = cell_q[MAX_ITEMS-1].vld;
  assign in_stall_o = drain_q;

  assign out_valid_o = drain_q && cell_q[0].vld;
  assign drain_end   = out_valid_o && !out_stall_i && !cell_q[1].vld;

  assign ctl.ins_en   = in_acc && !full;
  assign ctl.shift_en = out_valid_o && !out_stall_i;
  assign ctl.value    = in_data_i.item_value;

  for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
    cell_t left, right;
    logic  left_open;
    if (i == 0) begin : g_first
      assign left      = '{vld: 1'b1, val: '0};
      assign left_open = 1'b0;
    end else begin : g_mid
      assign left      = cell_q[i-1];
      assign left_open = open_w[i-1];
    end
    if (i == MAX_ITEMS-1) begin : g_last
      assign right = '{vld: 1'b0, val: '0};
    end else begin : g_inner
      assign right = cell_q[i+1];
    end
    bsa_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctl_i       (ctl),
      .left_i      (left),
      .left_open_i (left_open),
      .right_i     (right),
      .q_o         (cell_q[i]),
      .open_o      (open_w[i])
    );
  end

  always_comb begin
    drain_d = drain_q;
    ovf_d   = ovf_q;
    if (in_acc && full) begin
      ovf_d = 1'b1;
    end
    if (in_acc && in_data_i.is_last) begin
      drain_d = 1'b1;
    end
    if (drain_end) begin
      drain_d = 1'b0;
      ovf_d   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drain_q <= 1'b0;
      ovf_q   <= 1'b0;
    end else begin
      drain_q <= drain_d;
      ovf_q   <= ovf_d;
    end
  end

  assign out_data_o.sorted_value = cell_q[0].val;
  assign out_data_o.last_out     = !cell_q[1].vld;
  assign out_data_o.overflowed   = ovf_q;

endmodule

// ----- hdl/bsa_checker.sv -----
// Port-level checks for bucket_sort_ascending, attached by bind.
// Depends on bsa_pkg.
module bsa_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input bsa_pkg::in_item_t  in_data_i,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input bsa_pkg::out_item_t out_data_o
);

  // no loading while results are pending
  a_stall_on_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input not stalled during drain");

  // drain starts only after an accepted last item
  a_drain_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o && in_data_i.is_last))
    else $error("results without a last item");

  // final item closes the set
  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && out_data_o.last_out) |=> !out_valid_o)
    else $error("result after last_out");

  // stalled output holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("stalled output changed");

endmodule

bind bucket_sort_ascending bsa_checker u_bsa_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
